// ----- hdl/assert_macros.svh -----
// Assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication on the same edge
`define CHK_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Implication one edge later
`define CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/sact_pkg.sv -----
package sact_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_REPLACE   = 2'd0;
	localparam logic [1:0] REG_WRITEBACK = 2'd1;
	localparam logic [1:0] REG_WRALLOC   = 2'd2;
	localparam logic [1:0] REG_BYPASS    = 2'd3;

	// Replacement modes; the unused code behaves as LRU
	localparam logic [1:0] RM_LRU  = 2'd0;
	localparam logic [1:0] RM_RAND = 2'd1;
	localparam logic [1:0] RM_PLRU = 2'd2;

	localparam logic [15:0] LFSR_TAPS  = 16'hB400;
	localparam logic [15:0] LFSR_SEED  = 16'h0001;
	localparam int          BLK_ADDR_W = 26;

	typedef struct packed {
		logic        opcode;
		logic [31:0] address;
	} req_t;

	typedef struct packed {
		logic                  hit;
		logic [1:0]            way;
		logic                  bypassed;
		logic                  fill_request;
		logic [BLK_ADDR_W-1:0] fill_block_address;
		logic                  writeback_request;
		logic [BLK_ADDR_W-1:0] victim_block_address;
		logic                  write_through;
		logic                  forward_write;
	} res_t;

	typedef struct packed {
		logic [1:0] replace_mode;
		logic       write_back_mode;
		logic       write_allocate_mode;
		logic       bypass_enable;
	} cfg_t;

	// Control between the request queue and the back end
	typedef struct packed {
		logic pop;
		logic clearing;
	} fq_ctl_t;

endpackage

// ----- hdl/sact_front.sv -----
module sact_front #(
	parameter int SETS        = 64,
	parameter int BLOCK_BYTES = 64
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	output logic                                   full,
	input  sact_pkg::req_t                         req,
	input  sact_pkg::fq_ctl_t                      ctl,
	output logic                                   fq_empty,
	output logic                                   fq_write,
	output logic [((SETS > 1) ? $clog2(SETS + 1) - 1 : 1)-1:0] fq_set,
	output logic [32-($clog2(BLOCK_BYTES + 1) - 1)-($clog2(SETS + 1) - 1)-1:0] fq_tag,
	output logic [sact_pkg::BLK_ADDR_W-1:0]        fq_blk
);
	import sact_pkg::*;

	localparam int OFF_W  = $clog2(BLOCK_BYTES + 1) - 1;
	localparam int IDX_W  = $clog2(SETS + 1) - 1;
	localparam int ROW_AW = (IDX_W > 0) ? IDX_W : 1;
	localparam int TAG_W  = 32 - OFF_W - IDX_W;
	localparam logic [ROW_AW-1:0] SET_MASK = ROW_AW'((1 << IDX_W) - 1);

	logic              wr_q   [2];
	logic [ROW_AW-1:0] set_q  [2];
	logic [TAG_W-1:0]  tag_q  [2];
	logic [BLK_ADDR_W-1:0] blk_q [2];
	logic              wp_q, rp_q;
	logic [1:0]        cnt_q;
	logic              acc;

	// Hold off new transactions while full or while the tag store clears
	assign full     = (cnt_q == 2'd2) || ctl.clearing;
	assign acc      = push && !full;
	assign fq_empty = (cnt_q == 2'd0);
	assign fq_write = wr_q[rp_q];
	assign fq_set   = set_q[rp_q];
	assign fq_tag   = tag_q[rp_q];
	assign fq_blk   = blk_q[rp_q];

	// Split the address and store the classified request
	always_ff @(posedge clk) begin
		if (acc) begin
			wr_q[wp_q]  <= req.opcode;
			set_q[wp_q] <= ROW_AW'(req.address >> OFF_W) & SET_MASK;
			tag_q[wp_q] <= TAG_W'(req.address >> (OFF_W + IDX_W));
			blk_q[wp_q] <= BLK_ADDR_W'(req.address >> OFF_W);
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (acc)
				wp_q <= ~wp_q;
			if (ctl.pop)
				rp_q <= ~rp_q;
			if (acc && !ctl.pop)
				cnt_q <= cnt_q + 2'd1;
			else if (!acc && ctl.pop)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

// ----- hdl/sact_back.sv -----
module sact_back #(
	parameter int SETS          = 64,
	parameter int WAYS          = 4,
	parameter int BLOCK_BYTES   = 64,
	parameter int HISTORY_DEPTH = 4
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  sact_pkg::cfg_t                         cfg,
	input  logic                                   fq_empty,
	input  logic                                   fq_write,
	input  logic [((SETS > 1) ? $clog2(SETS + 1) - 1 : 1)-1:0] fq_set,
	input  logic [32-($clog2(BLOCK_BYTES + 1) - 1)-($clog2(SETS + 1) - 1)-1:0] fq_tag,
	input  logic [sact_pkg::BLK_ADDR_W-1:0]        fq_blk,
	output sact_pkg::fq_ctl_t                      ctl,
	output logic                                   empty,
	input  logic                                   pop,
	output sact_pkg::res_t                         res
);
	import sact_pkg::*;

	localparam int OFF_W  = $clog2(BLOCK_BYTES + 1) - 1;
	localparam int IDX_W  = $clog2(SETS + 1) - 1;
	localparam int ROW_AW = (IDX_W > 0) ? IDX_W : 1;
	localparam int ROWS   = 1 << IDX_W;
	localparam int TAG_W  = 32 - OFF_W - IDX_W;
	localparam int BA_W   = 32 - OFF_W;
	localparam int IX_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int AGE_W  = IX_W;
	localparam int LV     = $clog2(WAYS);
	localparam int NODE_W = IX_W + 2;
	localparam int HD     = HISTORY_DEPTH;
	localparam logic [AGE_W-1:0] OLDEST = AGE_W'(WAYS - 1);
	// Reciprocal of the way count, exact for every 16-bit LFSR value
	localparam int RL = (WAYS > 1) ? $clog2(WAYS) : 0;
	localparam int RK = 16 + RL;
	localparam logic [16:0] RECIP = 17'(((64'd1 << RK) + 64'(WAYS) - 64'd1) / 64'(WAYS));

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_EVAL = 3'd2;
	localparam logic [2:0] ST_REM  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	typedef struct packed {
		logic [WAYS-1:0]                  valid;
		logic [WAYS-1:0]                  dirty;
		logic [WAYS-1:0][AGE_W-1:0]       age;
		logic [WAYS-1:0][TAG_W-1:0]       tag;
		logic [WAYS-1:0]                  tree;
		logic [HD-1:0]                    hvalid;
		logic [HD-1:0][TAG_W-1:0]         htag;
	} row_t;

	row_t              mem [ROWS];
	row_t              row_q;
	row_t              nrow;
	logic              mem_we;
	logic [ROW_AW-1:0] mem_wa;
	row_t              mem_wd;
	logic              rd_en;

	logic [2:0]        st_q;
	logic [ROW_AW-1:0] clr_q;
	logic              wr_q;
	logic [ROW_AW-1:0] set_q;
	logic [TAG_W-1:0]  tag_q;
	logic [BLK_ADDR_W-1:0] blk_q;
	logic [15:0]       lfsr_q;
	logic [15:0]       lfsr_nx;
	logic [3:0]        rem_q;
	logic [3:0]        rem_nx;
	logic [32:0]       rprod;
	logic [15:0]       rquo;
	logic [15:0]       rmul;
	logic [15:0]       rdif;
	logic              out_v_q;
	res_t              out_q;
	res_t              res_nx;
	logic              commit;

	logic [WAYS-1:0]   hit_vec;
	logic              hit, all_valid, hist_match, skip, is_fwd, alloc, do_fill;
	logic              do_touch, need_rand;
	logic [IX_W-1:0]   hit_way, inv_way, lru_way, plru_way, victim, tw;
	logic [AGE_W-1:0]  old_rank;
	logic [BA_W-1:0]   vblk;

	assign ctl.pop      = (st_q == ST_IDLE) && !fq_empty && !out_v_q;
	assign ctl.clearing = (st_q == ST_CLR);
	assign rd_en        = ctl.pop;
	assign commit       = ((st_q == ST_EVAL) && !need_rand) || (st_q == ST_FIN);
	assign empty        = !out_v_q;
	assign res          = out_q;
	assign lfsr_nx      = (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_TAPS : 16'h0000);

	// Tag store, one row per set
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (rd_en)
			row_q <= mem[fq_set];
	end

	assign mem_we = (st_q == ST_CLR) || commit;
	assign mem_wa = (st_q == ST_CLR) ? clr_q : set_q;
	assign mem_wd = (st_q == ST_CLR) ? row_t'(0) : nrow;

	// Lookup and way classification
	always_comb begin
		hit_vec   = '0;
		hit_way   = '0;
		inv_way   = '0;
		lru_way   = '0;
		hist_match = 1'b0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			hit_vec[i] = row_q.valid[i] && (row_q.tag[i] == tag_q);
			if (hit_vec[i])
				hit_way = IX_W'(i);
			if (!row_q.valid[i])
				inv_way = IX_W'(i);
			if (row_q.age[i] == OLDEST)
				lru_way = IX_W'(i);
		end
		for (int k = 0; k < HD; k++)
			if (row_q.hvalid[k] && (row_q.htag[k] == tag_q))
				hist_match = 1'b1;
		hit       = |hit_vec;
		all_valid = &row_q.valid;
		is_fwd    = !hit && wr_q && !cfg.write_allocate_mode;
		alloc     = !hit && !is_fwd;
		skip      = cfg.bypass_enable && all_valid && (&row_q.hvalid) && !hist_match;
		do_fill   = alloc && !skip;
		need_rand = do_fill && all_valid && (cfg.replace_mode == RM_RAND);
	end

	// Walk the pseudo-LRU tree, least significant index bit first
	always_comb begin
		logic [NODE_W-1:0] node;
		logic              b;
		node     = NODE_W'(1);
		plru_way = '0;
		for (int k = 0; k < LV; k++) begin
			if (node < NODE_W'(WAYS)) begin
				b = row_q.tree[node[IX_W-1:0]];
				plru_way[k] = b;
				node = {node[NODE_W-2:0], 1'b0} + NODE_W'(b);
			end
		end
		if ({1'b0, plru_way} >= (IX_W + 1)'(WAYS))
			plru_way = IX_W'(WAYS - 1);
	end

	// Pick the victim and build the updated row
	always_comb begin
		logic [NODE_W-1:0] node;
		logic [IX_W-1:0]   t;
		if (!all_valid)
			victim = inv_way;
		else begin
			case (cfg.replace_mode)
				RM_RAND: victim = IX_W'(rem_q);
				RM_PLRU: victim = plru_way;
				default: victim = lru_way;
			endcase
		end
		tw       = hit ? hit_way : victim;
		old_rank = hit ? row_q.age[hit_way] : OLDEST;
		do_touch = hit || do_fill;
		nrow     = row_q;
		if (hit && wr_q)
			nrow.dirty[hit_way] = 1'b1;
		if (do_fill) begin
			nrow.valid[victim] = 1'b1;
			nrow.dirty[victim] = wr_q;
			nrow.tag[victim]   = tag_q;
		end
		if (alloc && cfg.bypass_enable) begin
			for (int k = HD - 1; k > 0; k--) begin
				nrow.htag[k]   = row_q.htag[k-1];
				nrow.hvalid[k] = row_q.hvalid[k-1];
			end
			nrow.htag[0]   = tag_q;
			nrow.hvalid[0] = 1'b1;
		end
		node = NODE_W'(1);
		t    = tw;
		if (do_touch) begin
			for (int i = 0; i < WAYS; i++)
				if ((IX_W'(i) != tw) && row_q.valid[i] && (row_q.age[i] < old_rank))
					nrow.age[i] = row_q.age[i] + AGE_W'(1);
			nrow.age[tw] = '0;
			for (int k = 0; k < LV; k++) begin
				if (node < NODE_W'(WAYS)) begin
					nrow.tree[node[IX_W-1:0]] = !t[0];
					node = {node[NODE_W-2:0], 1'b0} + NODE_W'(t[0]);
					t = t >> 1;
				end
			end
		end
	end

	// Form the result
	always_comb begin
		vblk = (BA_W'(row_q.tag[victim]) << IDX_W) | BA_W'(set_q);
		res_nx = '0;
		res_nx.hit                = hit;
		res_nx.way                = hit ? 2'(hit_way) : (do_fill ? 2'(victim) : 2'd0);
		res_nx.bypassed           = alloc && skip;
		res_nx.fill_request       = do_fill;
		res_nx.fill_block_address = blk_q;
		res_nx.writeback_request  = do_fill && cfg.write_back_mode && row_q.valid[victim]
			&& row_q.dirty[victim];
		if (res_nx.writeback_request)
			res_nx.victim_block_address = BLK_ADDR_W'(vblk);
		res_nx.write_through      = hit && wr_q && !cfg.write_back_mode;
		res_nx.forward_write      = is_fwd;
	end

	// Remainder of the LFSR value by the way count through a reciprocal multiply
	always_comb begin
		rprod  = 33'(lfsr_q) * 33'(RECIP);
		rquo   = 16'(rprod >> RK);
		rmul   = rquo * 16'(WAYS);
		rdif   = lfsr_q - rmul;
		rem_nx = rdif[3:0];
	end

	// Hold request fields for the transaction in flight, its result and LFSR remainder
	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			wr_q  <= fq_write;
			set_q <= fq_set;
			tag_q <= fq_tag;
			blk_q <= fq_blk;
		end
		if (commit)
			out_q <= res_nx;
		if (st_q == ST_REM)
			rem_q <= rem_nx;
	end

	// Sequence clear, lookup, random choice and commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_CLR;
			clr_q   <= '0;
			lfsr_q  <= LFSR_SEED;
			out_v_q <= 1'b0;
		end else begin
			if (commit)
				out_v_q <= 1'b1;
			else if (pop)
				out_v_q <= 1'b0;
			case (st_q)
				ST_CLR: begin
					clr_q <= clr_q + ROW_AW'(1);
					if (clr_q == ROW_AW'(ROWS - 1))
						st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (ctl.pop)
						st_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (need_rand) begin
						lfsr_q <= lfsr_nx;
						st_q   <= ST_REM;
					end else
						st_q <= ST_IDLE;
				end
				ST_REM: st_q <= ST_FIN;
				ST_FIN: st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- hdl/set_assoc_cache_tag_controller.sv -----
// Tag and replacement controller of a set-associative cache. Requests enter a
// two-entry queue; the back end then reads the set's row from a single-port
// tag store (one registered read, one write per cycle), compares all ways,
// chooses a victim and writes the row back, registering the result in EVAL
// or, on a miss with a full set in random mode, in FIN after REM takes the
// LFSR remainder. After reset a clear pass writes all 2**floor(log2(SETS)) set
// rows, one a cycle, with full held high. The user must write registers by
// index via cfg_we/cfg_index/cfg_data only while idle; no logic checks it.
module set_assoc_cache_tag_controller #(
	parameter int SETS          = 64,
	parameter int WAYS          = 4,
	parameter int BLOCK_BYTES   = 64,
	parameter int HISTORY_DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  sact_pkg::req_t  req,
	output logic            empty,
	input  logic            pop,
	output sact_pkg::res_t  res,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_index,
	input  logic [1:0]      cfg_data
);
	import sact_pkg::*;

	localparam int OFF_W  = $clog2(BLOCK_BYTES + 1) - 1;
	localparam int IDX_W  = $clog2(SETS + 1) - 1;
	localparam int ROW_AW = (IDX_W > 0) ? IDX_W : 1;
	localparam int TAG_W  = 32 - OFF_W - IDX_W;

	cfg_t                  cfg_q;
	fq_ctl_t               ctl;
	logic                  fq_empty, fq_write;
	logic [ROW_AW-1:0]     fq_set;
	logic [TAG_W-1:0]      fq_tag;
	logic [BLK_ADDR_W-1:0] fq_blk;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.replace_mode        <= RM_LRU;
			cfg_q.write_back_mode     <= 1'b1;
			cfg_q.write_allocate_mode <= 1'b1;
			cfg_q.bypass_enable       <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_REPLACE:   cfg_q.replace_mode        <= cfg_data;
				REG_WRITEBACK: cfg_q.write_back_mode     <= cfg_data[0];
				REG_WRALLOC:   cfg_q.write_allocate_mode <= cfg_data[0];
				REG_BYPASS:    cfg_q.bypass_enable       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	sact_front #(
		.SETS(SETS),
		.BLOCK_BYTES(BLOCK_BYTES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req(req),
		.ctl(ctl),
		.fq_empty(fq_empty),
		.fq_write(fq_write),
		.fq_set(fq_set),
		.fq_tag(fq_tag),
		.fq_blk(fq_blk)
	);

	sact_back #(
		.SETS(SETS),
		.WAYS(WAYS),
		.BLOCK_BYTES(BLOCK_BYTES),
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.fq_empty(fq_empty),
		.fq_write(fq_write),
		.fq_set(fq_set),
		.fq_tag(fq_tag),
		.fq_blk(fq_blk),
		.ctl(ctl),
		.empty(empty),
		.pop(pop),
		.res(res)
	);

endmodule

// ----- hdl/sact_checker.sv -----
`include "assert_macros.svh"

module sact_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           empty,
	input logic           pop,
	input sact_pkg::res_t res
);
	import sact_pkg::*;

	// A hit never fills
	`CHK_SAME(a_hit_no_fill, !empty && res.hit, !res.fill_request, "hit with fill")
	// A write-back only accompanies a fill
	`CHK_SAME(a_wb_fill, !empty && res.writeback_request, res.fill_request, "orphan write-back")
	// Bypassed or forwarded misses leave the way at zero and allocate nothing
	`CHK_SAME(a_no_alloc, !empty && (res.bypassed || res.forward_write), !res.hit && !res.fill_request && (res.way == 2'd0), "bad no-allocate result")
	// A waiting transaction holds until taken
	`CHK_NEXT(a_hold, !empty && !pop, !empty && $stable(res), "result changed while stalled")

endmodule

bind set_assoc_cache_tag_controller sact_checker u_chk (.*);
